[src/plse_pkg.sv]
// Shared types and constants for the piecewise-linear spectrum evaluator.
// Holds field widths, stream packing offsets, item kinds and the controller states.
// No dependencies.
package plse_pkg;

   localparam int WL_W      = 16;  // wavelength, unsigned Q10.6
   localparam int VAL_W     = 32;  // spectral value, unsigned Q16.16
   localparam int IDX_W     = 6;   // breakpoint slot field
   localparam int CFG_W     = 7;   // points_in_use register
   localparam int FRAC_W    = 16;  // fractional bits of t
   localparam int T_W       = FRAC_W + 1;
   localparam int PROD_W    = VAL_W + T_W;
   localparam int DIV_CNT_W = 4;

   localparam logic [T_W-1:0]       T_ONE        = T_W'(1) << FRAC_W;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(FRAC_W - 1);
   localparam logic [CFG_W-1:0]     POINTS_RESET = CFG_W'(2);
   localparam int                   MIN_POINTS   = 2;

   // Request tdata packing, lowest bit first.
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_WL_LSB    = REQ_IDX_LSB + IDX_W;
   localparam int REQ_VAL_LSB   = REQ_WL_LSB + WL_W;
   localparam int REQ_QUERY_LSB = REQ_VAL_LSB + VAL_W;
   localparam int REQ_TDATA_W   = 72;
   localparam int RSP_TDATA_W   = VAL_W;

   // Item kinds carried on req_tuser.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVAL  = 1'b1;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_CHK_LO = 12'b0000_0000_0010,
      ST_CHK_HI = 12'b0000_0000_0100,
      ST_SRCH   = 12'b0000_0000_1000,
      ST_STEP   = 12'b0000_0001_0000,
      ST_FETCH  = 12'b0000_0010_0000,
      ST_LOAD0  = 12'b0000_0100_0000,
      ST_LOAD1  = 12'b0000_1000_0000,
      ST_DIV    = 12'b0001_0000_0000,
      ST_MUL0   = 12'b0010_0000_0000,
      ST_MUL1   = 12'b0100_0000_0000,
      ST_FINISH = 12'b1000_0000_0000
   } state_type;

endpackage

[src/plse_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Width and depth are parameters. No dependencies.
module plse_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/piecewise_linear_spectrum_eval_top.sv]
// Piecewise-linear spectrum evaluator: top level with breakpoint table and controller.
// Depends on plse_pkg and plse_ram.
//
// The block keeps up to MAX_POINTS breakpoints (wavelength, value) in one RAM with a
// registered read, and all work goes through that single read port. A write transfer
// (tuser 0) stores one breakpoint. An evaluate transfer (tuser 1) reads the first and
// last active breakpoints. A query below the first one or above the last one returns
// zero with the outside flag set. Otherwise a binary search makes at most
// floor(log2(n-2)) + 1 probes for n > 2 and none for n = 2, the two bracketing breakpoints
// are read, a restoring divider forms the 16-bit fraction, and one shared multiplier
// blends the two values. The divider is skipped when the span is flat or falling,
// when the query lies below the interval start, or when the fraction saturates.
// A finished result waits in an output register, so the next item is taken while it is
// unclaimed; a later result waits until that register is free. The user must write
// points_in_use via csr_we only while the block is idle; the block itself does not
// enforce this. Values below 2 act as 2 and values above MAX_POINTS as MAX_POINTS.
module piecewise_linear_spectrum_eval_top #(
   parameter int MAX_POINTS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration: points_in_use.
   input  logic                                 csr_we,
   input  logic [plse_pkg::CFG_W-1:0]           csr_wdata,
   // Request stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata from bit 0: entry_index[5:0], entry_wavelength[15:0], entry_value[31:0],
   // query_wavelength[15:0], two zero pad bits.
   input  logic [plse_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: kind (0 write breakpoint, 1 evaluate).
   input  logic                                 req_tuser,
   // Result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata from bit 0: result_value[31:0].
   output logic [plse_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: outside_range.
   output logic                                 rsp_tuser
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int NW = (CW > plse_pkg::CFG_W) ? CW : plse_pkg::CFG_W;
   localparam int RAM_W = plse_pkg::VAL_W + plse_pkg::WL_W;
   localparam logic [31:0] MAX_POINTS_W = 32'(MAX_POINTS);

   // Registers.
   plse_pkg::state_type              state_ff, state_in;
   logic [plse_pkg::CFG_W-1:0]       points_ff, points_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [plse_pkg::VAL_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                             rsp_flag_ff, rsp_flag_in;
   logic [plse_pkg::WL_W-1:0]        query_ff, query_in;
   logic                             outside_ff, outside_in;
   logic [AW-1:0]                    first_ff, first_in;
   logic [AW-1:0]                    size_ff, size_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [plse_pkg::WL_W-1:0]        w0_ff, w0_in;
   logic [plse_pkg::VAL_W-1:0]       v0_ff, v0_in;
   logic [plse_pkg::VAL_W-1:0]       v1_ff, v1_in;
   logic [plse_pkg::WL_W-1:0]        den_ff, den_in;
   logic [plse_pkg::WL_W-1:0]        rem_ff, rem_in;
   logic [plse_pkg::T_W-1:0]         t_ff, t_in;
   logic [plse_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [plse_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [plse_pkg::PROD_W-1:0]      acc_ff, acc_in;

   // RAM ports.
   logic                             ram_we;
   logic [AW-1:0]                    ram_wr_addr;
   logic [RAM_W-1:0]                 ram_wr_data;
   logic [AW-1:0]                    ram_rd_addr;
   logic [RAM_W-1:0]                 ram_rd_data;
   logic [plse_pkg::WL_W-1:0]        rd_wl;
   logic [plse_pkg::VAL_W-1:0]       rd_val;

   // Datapath.
   logic                             req_xfer;
   logic [NW-1:0]                    points_wide;
   logic [NW-1:0]                    n_wide;
   logic [CW-1:0]                    n_act;
   logic [CW-1:0]                    n_minus1;
   logic [CW-1:0]                    n_minus2;
   logic [AW-1:0]                    half;
   logic [AW-1:0]                    mid;
   logic [AW-1:0]                    idx_raw;
   logic [AW-1:0]                    idx_clamped;
   logic [plse_pkg::WL_W-1:0]        diff;
   logic [plse_pkg::WL_W:0]          rem_shift;
   logic                             quot_bit;
   logic [plse_pkg::VAL_W-1:0]       mul_a;
   logic [plse_pkg::T_W-1:0]         mul_b;
   logic [plse_pkg::PROD_W-1:0]      mul_p;
   logic [plse_pkg::PROD_W-1:0]      blend_sum;
   logic                             out_free;

   assign req_tready = (state_ff == plse_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Breakpoint write straight from the request; slots past the table are dropped.
   assign ram_we      = req_xfer && (req_tuser == plse_pkg::KIND_WRITE) &&
                        (32'(req_tdata[plse_pkg::REQ_IDX_LSB +: plse_pkg::IDX_W]) <
                         MAX_POINTS_W);
   assign ram_wr_addr = AW'(req_tdata[plse_pkg::REQ_IDX_LSB +: plse_pkg::IDX_W]);
   assign ram_wr_data = {req_tdata[plse_pkg::REQ_VAL_LSB +: plse_pkg::VAL_W],
                         req_tdata[plse_pkg::REQ_WL_LSB +: plse_pkg::WL_W]};

   assign rd_wl  = ram_rd_data[plse_pkg::WL_W-1:0];
   assign rd_val = ram_rd_data[RAM_W-1:plse_pkg::WL_W];

   plse_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Active breakpoint count, clamped to the table.
   assign points_wide = NW'(points_ff);
   assign n_wide = (points_wide < NW'(plse_pkg::MIN_POINTS)) ? NW'(plse_pkg::MIN_POINTS) :
                   (points_wide > NW'(MAX_POINTS))          ? NW'(MAX_POINTS) : points_wide;
   assign n_act    = CW'(n_wide);
   assign n_minus1 = n_act - CW'(1);
   assign n_minus2 = n_act - CW'(2);

   // Search probe and the bracketing interval that the search leaves.
   assign half        = size_ff >> 1;
   assign mid         = first_ff + half;
   assign idx_raw     = first_ff - AW'(1);
   assign idx_clamped = (CW'(idx_raw) > n_minus2) ? AW'(n_minus2) : idx_raw;

   assign diff      = query_ff - w0_ff;
   assign rem_shift = {rem_ff, 1'b0};
   assign quot_bit  = (rem_shift >= {1'b0, den_ff});

   // One multiplier serves both weighted terms.
   assign mul_a     = (state_ff == plse_pkg::ST_MUL0) ? v0_ff : v1_ff;
   assign mul_b     = (state_ff == plse_pkg::ST_MUL0) ? (plse_pkg::T_ONE - t_ff) : t_ff;
   assign mul_p     = plse_pkg::PROD_W'(mul_a) * plse_pkg::PROD_W'(mul_b);
   assign blend_sum = acc_ff + prod_ff;

   always_comb begin
      unique case (state_ff)
         plse_pkg::ST_IDLE:   ram_rd_addr = '0;
         plse_pkg::ST_CHK_LO: ram_rd_addr = AW'(n_minus1);
         plse_pkg::ST_SRCH:   ram_rd_addr = mid;
         plse_pkg::ST_FETCH:  ram_rd_addr = idx_clamped;
         plse_pkg::ST_LOAD0:  ram_rd_addr = idx_ff + AW'(1);
         default:             ram_rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      points_in    = csr_we ? csr_wdata : points_ff;
      query_in     = query_ff;
      outside_in   = outside_ff;
      first_in     = first_ff;
      size_in      = size_ff;
      idx_in       = idx_ff;
      w0_in        = w0_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      t_in         = t_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         plse_pkg::ST_IDLE: begin
            if (req_xfer && (req_tuser == plse_pkg::KIND_EVAL)) begin
               query_in = req_tdata[plse_pkg::REQ_QUERY_LSB +: plse_pkg::WL_W];
               state_in = plse_pkg::ST_CHK_LO;
            end
         end
         plse_pkg::ST_CHK_LO: begin
            if (query_ff < rd_wl) begin
               outside_in = 1'b1;
               state_in   = plse_pkg::ST_FINISH;
            end else begin
               state_in = plse_pkg::ST_CHK_HI;
            end
         end
         plse_pkg::ST_CHK_HI: begin
            first_in = AW'(1);
            size_in  = AW'(n_minus2);
            if (query_ff > rd_wl) begin
               outside_in = 1'b1;
               state_in   = plse_pkg::ST_FINISH;
            end else begin
               outside_in = 1'b0;
               state_in   = (n_minus2 == '0) ? plse_pkg::ST_FETCH : plse_pkg::ST_SRCH;
            end
         end
         plse_pkg::ST_SRCH: begin
            state_in = plse_pkg::ST_STEP;
         end
         plse_pkg::ST_STEP: begin
            if (rd_wl <= query_ff) begin
               first_in = mid + AW'(1);
               size_in  = size_ff - half - AW'(1);
            end else begin
               size_in = half;
            end
            state_in = (size_in == '0) ? plse_pkg::ST_FETCH : plse_pkg::ST_SRCH;
         end
         plse_pkg::ST_FETCH: begin
            idx_in   = idx_clamped;
            state_in = plse_pkg::ST_LOAD0;
         end
         plse_pkg::ST_LOAD0: begin
            w0_in    = rd_wl;
            v0_in    = rd_val;
            state_in = plse_pkg::ST_LOAD1;
         end
         plse_pkg::ST_LOAD1: begin
            v1_in  = rd_val;
            den_in = rd_wl - w0_ff;
            rem_in = diff;
            cnt_in = plse_pkg::DIV_LAST_CNT;
            t_in   = '0;
            // A flat or falling span, or a query below w0, gives t = 0; a quotient of one or more saturates.
            if (!(rd_wl > w0_ff) || (query_ff < w0_ff)) begin
               state_in = plse_pkg::ST_MUL0;
            end else if (diff >= (rd_wl - w0_ff)) begin
               t_in     = plse_pkg::T_ONE;
               state_in = plse_pkg::ST_MUL0;
            end else begin
               state_in = plse_pkg::ST_DIV;
            end
         end
         plse_pkg::ST_DIV: begin
            rem_in = quot_bit ? plse_pkg::WL_W'(rem_shift - {1'b0, den_ff})
                              : rem_shift[plse_pkg::WL_W-1:0];
            t_in   = {t_ff[plse_pkg::T_W-2:0], quot_bit};
            cnt_in = cnt_ff - plse_pkg::DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = plse_pkg::ST_MUL0;
            end
         end
         plse_pkg::ST_MUL0: begin
            prod_in  = mul_p;
            state_in = plse_pkg::ST_MUL1;
         end
         plse_pkg::ST_MUL1: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = plse_pkg::ST_FINISH;
         end
         plse_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = outside_ff;
               rsp_data_in  = outside_ff ? '0
                              : blend_sum[plse_pkg::FRAC_W +: plse_pkg::VAL_W];
               state_in     = plse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plse_pkg::ST_IDLE;
         points_ff    <= plse_pkg::POINTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      outside_ff  <= outside_in;
      first_ff    <= first_in;
      size_ff     <= size_in;
      idx_ff      <= idx_in;
      w0_ff       <= w0_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      t_ff        <= t_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   // An out-of-range result always carries a zero value.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("outside-range result with nonzero value");

   // Every search probe stays inside the interior of the active table.
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plse_pkg::ST_SRCH) |-> ((CW'(mid) <= n_minus2) && (mid != '0)))
      else $error("search probe outside the active breakpoints");

   // The fraction entering the blend never exceeds one.
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plse_pkg::ST_MUL0) |-> (t_ff <= plse_pkg::T_ONE))
      else $error("interpolation fraction above one");

   // A new result is only loaded once the previous one has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plse_pkg::ST_FINISH && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == plse_pkg::ST_FINISH))
      else $error("pending result overwritten");

endmodule

[bench/piecewise_linear_spectrum_eval_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_spectrum_eval_top: breakpoint writes and
// interpolation queries are predicted in the bench and every result is checked in order.
// Depends on plse_pkg and the evaluator RTL.
module piecewise_linear_spectrum_eval_top_test;

   localparam int CLOCK_PERIOD  = 20;
   localparam int TABLE_DEPTH   = 64;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [plse_pkg::VAL_W-1:0] level;
      logic                       outside;
   } spectrum_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [plse_pkg::CFG_W-1:0]       csr_wdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [plse_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [plse_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;

   // Bench copy of the block state.
   logic [plse_pkg::WL_W-1:0]  wl_table [TABLE_DEPTH];
   logic [plse_pkg::VAL_W-1:0] value_table [TABLE_DEPTH];
   logic [plse_pkg::CFG_W-1:0] points_reg = plse_pkg::POINTS_RESET;

   spectrum_result_type pending_results [$];
   spectrum_result_type oldest_result;
   int  error_count = 0;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  hold_remaining = 0;
   bit  sender_idle_enable = 1'b1;
   bit  receiver_idle_enable = 1'b1;

   piecewise_linear_spectrum_eval_top #(.MAX_POINTS(TABLE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned active_points();
      if (points_reg < plse_pkg::MIN_POINTS) return plse_pkg::MIN_POINTS;
      if (points_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(points_reg);
   endfunction

   // Updates the table for a write, or queues the interpolated value for a query.
   function automatic void predict_spectrum(input logic kind,
                                            input logic [plse_pkg::IDX_W-1:0] slot,
                                            input logic [plse_pkg::WL_W-1:0] wl,
                                            input logic [plse_pkg::VAL_W-1:0] val,
                                            input logic [plse_pkg::WL_W-1:0] q);
      int unsigned         n, first, size, half, mid;
      longint unsigned     w0, w1, v0, v1, delta, span, frac, blend;
      spectrum_result_type res;
      if (kind == plse_pkg::KIND_WRITE) begin
         wl_table[slot] = wl;
         value_table[slot] = val;
         return;
      end
      n = active_points();
      if (q < wl_table[0] || q > wl_table[n - 1]) begin
         res.level = '0;
         res.outside = 1'b1;
         pending_results.push_back(res);
         return;
      end
      // Fixed-shape binary search over slots 1..n-2 for the last w[mid] <= q.
      first = 1;
      size = n - 2;
      while (size > 0) begin
         half = size >> 1;
         mid = first + half;
         if (mid < TABLE_DEPTH && wl_table[mid] <= q) begin
            first = mid + 1;
            size = size - (half + 1);
         end else begin
            size = half;
         end
      end
      first = first - 1;
      if (first > n - 2) first = n - 2;
      w0 = wl_table[first];
      w1 = wl_table[first + 1];
      v0 = value_table[first];
      v1 = value_table[first + 1];
      frac = 0;
      if (w1 > w0 && q >= w0) begin
         delta = q - w0;
         span = w1 - w0;
         frac = (delta << plse_pkg::FRAC_W) / span;
         if (frac > 65536) frac = 65536;
      end
      blend = (v0 * (65536 - frac) + v1 * frac) >> plse_pkg::FRAC_W;
      res.level = blend[plse_pkg::VAL_W-1:0];
      res.outside = 1'b0;
      pending_results.push_back(res);
   endfunction

   task automatic send_item(input logic kind, input logic [plse_pkg::IDX_W-1:0] slot,
                            input logic [plse_pkg::WL_W-1:0] wl,
                            input logic [plse_pkg::VAL_W-1:0] val,
                            input logic [plse_pkg::WL_W-1:0] q);
      @(negedge clock);
      if (sender_idle_enable) begin
         while ($urandom_range(99) < 33) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, q, val, wl, slot};
      do @(posedge clock); while (!req_tready);
      predict_spectrum(kind, slot, wl, val, q);
      items_sent++;
   endtask

   task automatic write_breakpoint(input logic [plse_pkg::IDX_W-1:0] slot,
                                   input logic [plse_pkg::WL_W-1:0] wl,
                                   input logic [plse_pkg::VAL_W-1:0] val);
      send_item(plse_pkg::KIND_WRITE, slot, wl, val, plse_pkg::WL_W'($urandom));
   endtask

   task automatic evaluate_at(input logic [plse_pkg::WL_W-1:0] q);
      send_item(plse_pkg::KIND_EVAL, plse_pkg::IDX_W'($urandom), plse_pkg::WL_W'($urandom),
                $urandom, q);
   endtask

   // Stops offering items and waits until every queued result has been checked.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(input logic [plse_pkg::CFG_W-1:0] count);
      drain_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= count;
      points_reg = count;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   always @(negedge clock) begin
      if (hold_remaining > 0) begin
         rsp_tready <= 1'b0;
         hold_remaining = hold_remaining - 1;
      end else if (receiver_idle_enable) begin
         rsp_tready <= ($urandom_range(99) >= 33);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: level=%h outside=%b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tdata !== oldest_result.level || rsp_tuser !== oldest_result.outside) begin
               if (error_count < 10)
                  $display({"result mismatch: expected level=%h outside=%b, ",
                            "got level=%h outside=%b"},
                           oldest_result.level, oldest_result.outside, rsp_tdata, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Reset value of two points: endpoints, out-of-range edges, zero span, reversed pair.
   task automatic test_two_point_table();
      write_breakpoint(6'd0, 16'h0000, 32'h0000_0000);
      write_breakpoint(6'd1, 16'hFFFF, 32'hFFFF_FFFF);
      evaluate_at(16'h0000);
      evaluate_at(16'hFFFF);
      evaluate_at(16'h8000);
      evaluate_at(16'h0001);
      write_breakpoint(6'd0, 16'd100, 32'hFFFF_FFFF);
      write_breakpoint(6'd1, 16'd200, 32'h0000_0000);
      evaluate_at(16'd99);
      evaluate_at(16'd201);
      evaluate_at(16'd100);
      evaluate_at(16'd200);
      evaluate_at(16'd150);
      write_breakpoint(6'd1, 16'd100, 32'h1234_5678);
      evaluate_at(16'd100);
      evaluate_at(16'd101);
      write_breakpoint(6'd1, 16'd50, 32'h0000_0001);
      evaluate_at(16'd75);
   endtask

   // Fills every slot, then walks the register through its clamped and extreme settings.
   task automatic test_register_limits();
      int k;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         write_breakpoint(plse_pkg::IDX_W'(k),
                          (k == TABLE_DEPTH - 1) ? 16'hFFFF : plse_pkg::WL_W'(k * 1040),
                          (k % 3 == 0) ? 32'h0 : (k % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
      end
      set_point_count(7'd127);
      evaluate_at(16'h0000);
      evaluate_at(16'hFFFF);
      evaluate_at(16'hFFFE);
      evaluate_at(16'd32240);
      evaluate_at(16'd32241);
      set_point_count(7'd0);
      evaluate_at(16'd1040);
      evaluate_at(16'd1041);
      set_point_count(7'd1);
      evaluate_at(16'd520);
      set_point_count(7'd64);
      evaluate_at(plse_pkg::WL_W'($urandom));
      evaluate_at(16'd65000);
      set_point_count(7'd65);
      evaluate_at(16'hFFFF);
      set_point_count(7'd3);
      evaluate_at(16'd1000);
      evaluate_at(16'd2080);
      evaluate_at(16'd2081);
   endtask

   // Rounds of: pick a point count, load an ascending table, then query it, with the
   // odd stray write that may leave the table unsorted.
   task automatic test_random_tables(input int item_goal);
      int unsigned n, base, max_step, accum, lo, hi, queries, k, j;
      int          mode;
      logic [plse_pkg::VAL_W-1:0] val;
      logic [plse_pkg::WL_W-1:0]  q;
      while (items_sent < item_goal) begin
         case ($urandom_range(9))
            0:       set_point_count(plse_pkg::CFG_W'($urandom_range(1)));
            1:       set_point_count(plse_pkg::CFG_W'($urandom_range(127, 64)));
            2:       set_point_count(7'd2);
            3:       set_point_count(7'd3);
            default: set_point_count(plse_pkg::CFG_W'($urandom_range(24, 4)));
         endcase
         n = active_points();
         base = ($urandom_range(3) == 0) ? 0 : $urandom_range(20000);
         max_step = (65535 - base) / (n - 1);
         accum = base;
         mode = $urandom_range(2);
         for (k = 0; k < n; k++) begin
            if (k > 0)
               accum = accum + (($urandom_range(15) == 0) ? 0 : $urandom_range(max_step, 1));
            if (k == n - 1 && $urandom_range(3) == 0) accum = 65535;
            case (mode)
               0:       val = $urandom;
               1:       val = $urandom_range(32'h0010_0000);
               default: val = k[0] ? 32'hFFFF_FFFF : 32'h0;
            endcase
            write_breakpoint(plse_pkg::IDX_W'(k), plse_pkg::WL_W'(accum), val);
         end
         queries = $urandom_range(40, 10);
         for (j = 0; j < queries; j++) begin
            if ($urandom_range(11) == 0)
               write_breakpoint(plse_pkg::IDX_W'($urandom), plse_pkg::WL_W'($urandom),
                                $urandom);
            lo = 32'(wl_table[0]);
            hi = 32'(wl_table[n - 1]);
            case ($urandom_range(9))
               6:       q = wl_table[$urandom_range(n - 1)];
               7:       q = $urandom_range(1) ? plse_pkg::WL_W'(lo - 1)
                                              : plse_pkg::WL_W'(hi + 1);
               8, 9:    q = plse_pkg::WL_W'($urandom);
               default: q = (lo <= hi) ? plse_pkg::WL_W'($urandom_range(hi, lo))
                                       : plse_pkg::WL_W'($urandom);
            endcase
            evaluate_at(q);
         end
      end
   endtask

   task automatic test_back_to_back();
      sender_idle_enable = 1'b0;
      receiver_idle_enable = 1'b0;
      test_random_tables(items_sent + 200);
      sender_idle_enable = 1'b1;
      receiver_idle_enable = 1'b1;
   endtask

   // The receiver holds off while queries keep coming, so the block must stall its input.
   task automatic test_result_backpressure();
      int j;
      drain_results();
      set_point_count(7'd64);
      sender_idle_enable = 1'b0;
      hold_remaining = HOLD_CYCLES;
      for (j = 0; j < 12; j++)
         evaluate_at(plse_pkg::WL_W'($urandom_range(wl_table[TABLE_DEPTH - 1], wl_table[0])));
      drain_results();
      sender_idle_enable = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_two_point_table();
      test_register_limits();
      test_random_tables(900);
      test_back_to_back();
      test_result_backpressure();
      test_random_tables(1250);
      drain_results();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
